### rtl/slbs_pkg.sv
// ----------------------------------------------------------------------------
// slbs_pkg
// Shared types and constants of the status LED blink sequencer.
// ----------------------------------------------------------------------------
package slbs_pkg;

  typedef logic [2:0]  status_t;
  typedef logic [15:0] ms_t;
  typedef logic [23:0] pulse_t;

  // Status codes
  localparam status_t ST_DISCONNECTED = 3'd0;
  localparam status_t ST_SEARCHING    = 3'd1;
  localparam status_t ST_LTE          = 3'd2;
  localparam status_t ST_MQTT         = 3'd3;
  localparam status_t ST_ERROR        = 3'd4;
  localparam status_t ST_PUB_OK       = 3'd5;
  localparam status_t ST_PUB_ERR      = 3'd6;
  localparam status_t ST_INVALID      = 3'd7;

  // Item kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BLINK_HALF_MS = 3'd0;
  localparam cfg_idx_t CFG_FLASH_COUNT   = 3'd1;
  localparam cfg_idx_t CFG_FLASH_ON_MS   = 3'd2;
  localparam cfg_idx_t CFG_FLASH_OFF_MS  = 3'd3;
  localparam cfg_idx_t CFG_PWM_PERIOD    = 3'd4;

  localparam int unsigned CFG_DATA_W = 24;

  typedef struct packed {
    ms_t        blink_half_ms;
    logic [3:0] flash_count;
    ms_t        flash_on_ms;
    ms_t        flash_off_ms;
    pulse_t     pwm_period;
  } cfg_t;

  typedef struct packed {
    pulse_t  red_pulse;
    pulse_t  green_pulse;
    pulse_t  blue_pulse;
    status_t stable_code;
    status_t shown_code;
    logic    bad_request;
  } result_t;

  // Colour of a status: bit 2 red, bit 1 green, bit 0 blue
  function automatic logic [2:0] colour_of(input status_t code);
    logic [2:0] col;
    begin
      unique case (code)
        ST_DISCONNECTED, ST_ERROR, ST_PUB_ERR: col = 3'b100;
        ST_SEARCHING:                          col = 3'b001;
        ST_LTE:                                col = 3'b010;
        ST_MQTT:                               col = 3'b011;
        ST_PUB_OK:                             col = 3'b111;
        default:                               col = 3'b000;
      endcase
      return col;
    end
  endfunction

endpackage

### rtl/slbs_if.sv
// ----------------------------------------------------------------------------
// slbs_if
// Valid/ready channels of the sequencer: request items in, LED items out.
// ----------------------------------------------------------------------------
interface slbs_in_if;
  import slbs_pkg::*;

  logic    valid;
  logic    ready;
  logic    req_type;
  status_t status_code;

  modport source (output valid, output req_type, output status_code, input ready);
  modport sink   (input valid, input req_type, input status_code, output ready);
endinterface

interface slbs_out_if;
  import slbs_pkg::*;

  logic    valid;
  logic    ready;
  pulse_t  red_pulse;
  pulse_t  green_pulse;
  pulse_t  blue_pulse;
  status_t stable_code;
  status_t shown_code;
  logic    bad_request;

  modport source (output valid, output red_pulse, output green_pulse, output blue_pulse,
                  output stable_code, output shown_code, output bad_request,
                  input ready);
  modport sink   (input valid, input red_pulse, input green_pulse, input blue_pulse,
                  input stable_code, input shown_code, input bad_request,
                  output ready);
endinterface

### rtl/slbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// slbs_cfg_regs
// Configuration register file, write only, reset to the default timings.
// ----------------------------------------------------------------------------
module slbs_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  slbs_pkg::cfg_idx_t                    cfg_index,
  input  logic [slbs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output slbs_pkg::cfg_t                        cfg
);
  import slbs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_half_ms <= 16'd250;
      cfg_r.flash_count   <= 4'd5;
      cfg_r.flash_on_ms   <= 16'd150;
      cfg_r.flash_off_ms  <= 16'd150;
      cfg_r.pwm_period    <= 24'd20000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLINK_HALF_MS: cfg_r.blink_half_ms <= cfg_wdata[15:0];
        CFG_FLASH_COUNT:   cfg_r.flash_count   <= cfg_wdata[3:0];
        CFG_FLASH_ON_MS:   cfg_r.flash_on_ms   <= cfg_wdata[15:0];
        CFG_FLASH_OFF_MS:  cfg_r.flash_off_ms  <= cfg_wdata[15:0];
        CFG_PWM_PERIOD:    cfg_r.pwm_period    <= cfg_wdata[23:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/slbs_seq.sv
// ----------------------------------------------------------------------------
// slbs_seq
// Status state, blink and flash countdowns; next LED view for one item.
// ----------------------------------------------------------------------------
module slbs_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               req_type,
  input  slbs_pkg::status_t  status_code,
  input  slbs_pkg::cfg_t     cfg,
  output slbs_pkg::result_t  res
);
  import slbs_pkg::*;

  status_t    stable_r, stable_nxt;
  status_t    shown_r, shown_nxt;
  logic       blink_on_r, blink_on_nxt;
  logic       blink_armed_r, blink_armed_nxt;
  ms_t        blink_timer_r, blink_timer_nxt;
  logic       flash_on_r, flash_on_nxt;
  logic       flash_armed_r, flash_armed_nxt;
  ms_t        flash_timer_r, flash_timer_nxt;
  logic [3:0] flashes_left_r, flashes_left_nxt;
  logic       bad;
  logic       lit;
  logic [2:0] col;

  always_comb begin
    stable_nxt       = stable_r;
    shown_nxt        = shown_r;
    blink_on_nxt     = blink_on_r;
    blink_armed_nxt  = blink_armed_r;
    blink_timer_nxt  = blink_timer_r;
    flash_on_nxt     = flash_on_r;
    flash_armed_nxt  = flash_armed_r;
    flash_timer_nxt  = flash_timer_r;
    flashes_left_nxt = flashes_left_r;
    bad              = 1'b0;

    if (req_type == REQ_TICK) begin
      // blink countdown
      if (blink_armed_r) begin
        if (blink_timer_r <= 16'd1) begin
          blink_timer_nxt = '0;
          if (shown_r == ST_SEARCHING) begin
            blink_on_nxt    = ~blink_on_r;
            blink_armed_nxt = 1'b1;
            blink_timer_nxt = cfg.blink_half_ms;
          end else begin
            blink_on_nxt    = 1'b0;
            blink_armed_nxt = 1'b0;
          end
        end else begin
          blink_timer_nxt = blink_timer_r - 16'd1;
        end
      end
      // flash countdown; the last off phase hands back to the stable view
      if (flash_armed_r) begin
        if (flash_timer_r <= 16'd1) begin
          flash_timer_nxt = '0;
          if (flash_on_r) begin
            flash_on_nxt    = 1'b0;
            flash_timer_nxt = cfg.flash_off_ms;
          end else if (flashes_left_r > 4'd1) begin
            flashes_left_nxt = flashes_left_r - 4'd1;
            flash_on_nxt     = 1'b1;
            flash_timer_nxt  = cfg.flash_on_ms;
          end else begin
            flashes_left_nxt = '0;
            flash_on_nxt     = 1'b0;
            flash_armed_nxt  = 1'b0;
            shown_nxt        = stable_r;
            blink_on_nxt     = (stable_r == ST_SEARCHING);
            if (stable_r == ST_SEARCHING) begin
              blink_armed_nxt = 1'b1;
              blink_timer_nxt = cfg.blink_half_ms;
            end
          end
        end else begin
          flash_timer_nxt = flash_timer_r - 16'd1;
        end
      end
    end else begin
      case (status_code)
        ST_INVALID: begin
          bad = 1'b1;
        end
        ST_PUB_OK, ST_PUB_ERR: begin
          shown_nxt        = status_code;
          blink_on_nxt     = 1'b0;
          blink_armed_nxt  = 1'b0;
          blink_timer_nxt  = '0;
          flash_on_nxt     = 1'b1;
          flash_armed_nxt  = 1'b1;
          flashes_left_nxt = cfg.flash_count;
          flash_timer_nxt  = cfg.flash_on_ms;
        end
        default: begin
          stable_nxt      = status_code;
          shown_nxt       = status_code;
          flash_armed_nxt = 1'b0;
          flash_on_nxt    = 1'b0;
          flash_timer_nxt = '0;
          blink_on_nxt    = (status_code == ST_SEARCHING);
          blink_armed_nxt = (status_code == ST_SEARCHING);
          blink_timer_nxt = (status_code == ST_SEARCHING) ? cfg.blink_half_ms : '0;
        end
      endcase
    end

    lit = flash_armed_nxt ? flash_on_nxt
                          : !(shown_nxt == ST_SEARCHING && !blink_on_nxt);
    col = lit ? colour_of(shown_nxt) : 3'b000;

    // level is 0 or full scale, so period * level / 255 is period or zero
    res.red_pulse   = col[2] ? cfg.pwm_period : '0;
    res.green_pulse = col[1] ? cfg.pwm_period : '0;
    res.blue_pulse  = col[0] ? cfg.pwm_period : '0;
    res.stable_code = stable_nxt;
    res.shown_code  = shown_nxt;
    res.bad_request = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r       <= ST_DISCONNECTED;
      shown_r        <= ST_DISCONNECTED;
      blink_on_r     <= 1'b0;
      blink_armed_r  <= 1'b0;
      blink_timer_r  <= '0;
      flash_on_r     <= 1'b0;
      flash_armed_r  <= 1'b0;
      flash_timer_r  <= '0;
      flashes_left_r <= '0;
    end else if (step) begin
      stable_r       <= stable_nxt;
      shown_r        <= shown_nxt;
      blink_on_r     <= blink_on_nxt;
      blink_armed_r  <= blink_armed_nxt;
      blink_timer_r  <= blink_timer_nxt;
      flash_on_r     <= flash_on_nxt;
      flash_armed_r  <= flash_armed_nxt;
      flash_timer_r  <= flash_timer_nxt;
      flashes_left_r <= flashes_left_nxt;
    end
  end

endmodule

### rtl/status_led_blink_sequencer_core.sv
// ----------------------------------------------------------------------------
// status_led_blink_sequencer_core
// RGB status LED sequencer: solid, blinking and transient flash patterns.
// ----------------------------------------------------------------------------
// Usage
//  - in_item : one item per handshake; req_type 0 is a 1 ms tick, 1 is a
//    set-status request carrying status_code (code 7 is flagged, no effect).
//  - out_item: exactly one item per input item, in order: the three PWM
//    pulse widths, the stable and shown status, and the bad request flag.
//  - cfg_*   : write-only registers; user writes only while block idle (not enforced).
// Timing
//  - An accepted item is held in the input register, processed in a single
//    pass through the sequencer logic and lands in the output register
//    once the output register is free to take it.
//  - Throughput is one item per cycle while the receiver takes every item;
//    the limit is the sequencer state update feeding back into its registers.
// Stalls and reset
//  - While the receiver stalls, the output item holds and the input
//    register may still take one more item; then in_item.ready drops.
//  - Synchronous reset (rst_n low) empties both registers, loads the
//    default timings and returns the LED to disconnected (solid red).
// ----------------------------------------------------------------------------
module status_led_blink_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  slbs_in_if.sink                             in_item,
  slbs_out_if.source                          out_item,
  input  logic                                cfg_we,
  input  slbs_pkg::cfg_idx_t                  cfg_index,
  input  logic [slbs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import slbs_pkg::*;

  cfg_t    cfg;
  result_t res;

  // input register
  logic    s1_valid_r;
  logic    s1_req_r;
  status_t s1_code_r;

  // output register
  logic    out_valid_r;
  result_t out_r;

  logic    advance;   // output register free to take the next result
  logic    in_acc;

  assign advance        = !out_valid_r || out_item.ready;
  assign in_item.ready  = !s1_valid_r || advance;
  assign in_acc         = in_item.valid && in_item.ready;

  slbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // state moves on only when the held item is passed to the output register
  slbs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_valid_r && advance),
    .req_type    (s1_req_r),
    .status_code (s1_code_r),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_item.req_type;
      s1_code_r <= in_item.status_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_r <= res;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.red_pulse   = out_r.red_pulse;
  assign out_item.green_pulse = out_r.green_pulse;
  assign out_item.blue_pulse  = out_r.blue_pulse;
  assign out_item.stable_code = out_r.stable_code;
  assign out_item.shown_code  = out_r.shown_code;
  assign out_item.bad_request = out_r.bad_request;

  // Stable status is never a transient or invalid code
  a_stable_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.stable_code != ST_PUB_OK && out_r.stable_code != ST_PUB_ERR &&
                     out_r.stable_code != ST_INVALID))
    else $error("stable status holds a transient or invalid code");

  // Outside a flash the shown status is the stable one
  a_shown_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.shown_code != ST_PUB_OK && out_r.shown_code != ST_PUB_ERR)
      |-> out_r.shown_code == out_r.stable_code)
    else $error("shown status differs from stable status outside a flash");

  // Input back-pressure only when both registers are full and the sink stalls
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> (s1_valid_r && out_valid_r && !out_item.ready))
    else $error("input stalled with room in the pipeline");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the status LED sequencer: a table of directed
// items, then random phases under several timings, checked item by item
// against a cycle-free model of the LED pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import slbs_pkg::*;

  // Run shape
  localparam int DIR_ROWS        = 27;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int DRAIN_PAUSE     = 4;
  localparam int TAIL_CYCLES     = 8;
  localparam int HOLD_CYCLES     = 64;    // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any handshake

  localparam longint unsigned LEVEL_FULL = 64'd255;

  // Colour bits: red, green, blue
  localparam logic [2:0] RGB_OFF   = 3'b000;
  localparam logic [2:0] RGB_RED   = 3'b100;
  localparam logic [2:0] RGB_GREEN = 3'b010;
  localparam logic [2:0] RGB_BLUE  = 3'b001;
  localparam logic [2:0] RGB_CYAN  = 3'b011;
  localparam logic [2:0] RGB_WHITE = 3'b111;

  localparam pulse_t PWM_RESET = 24'd20000;
  localparam pulse_t PWM_FULL  = 24'hFFFFFF;

  // Expectations that can be read straight off the pattern rules
  localparam result_t NO_WANT       = '0;
  localparam result_t WANT_IDLE_RED =
    '{PWM_RESET, 24'd0, 24'd0, ST_DISCONNECTED, ST_DISCONNECTED, 1'b0};
  localparam result_t WANT_BAD_RED  =
    '{PWM_RESET, 24'd0, 24'd0, ST_DISCONNECTED, ST_DISCONNECTED, 1'b1};
  localparam result_t WANT_LTE      = '{24'd0, PWM_RESET, 24'd0, ST_LTE, ST_LTE, 1'b0};
  localparam result_t WANT_LTE_FULL = '{24'd0, PWM_FULL, 24'd0, ST_LTE, ST_LTE, 1'b0};
  localparam result_t WANT_DARK_ERR = '{24'd0, 24'd0, 24'd0, ST_ERROR, ST_ERROR, 1'b0};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  req;
    status_t               code;
    logic                  typed;    // want holds the expected item
    result_t               want;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  slbs_in_if  in_ch ();
  slbs_out_if out_ch ();

  status_led_blink_sequencer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Directed table. Reset defaults first, then short timers, a zero flash
  // count and full / zero PWM periods to hit the corner cases.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [DIR_ROWS] = '{
    // after reset: solid red, tick ignores its status code
    '{ROW_ITEM, REQ_TICK, ST_DISCONNECTED, 1'b1, WANT_IDLE_RED, CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_TICK, ST_INVALID,      1'b1, WANT_IDLE_RED, CFG_BLINK_HALF_MS, 24'd0},
    // invalid code flagged, nothing else moves
    '{ROW_ITEM, REQ_SET,  ST_INVALID,      1'b1, WANT_BAD_RED,  CFG_BLINK_HALF_MS, 24'd0},
    // searching twice: second one restarts the blink lit
    '{ROW_ITEM, REQ_SET,  ST_SEARCHING,    1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_SEARCHING,    1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_LTE,          1'b1, WANT_LTE,      CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_MQTT,         1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_ERROR,        1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_DISCONNECTED, 1'b1, WANT_IDLE_RED, CFG_BLINK_HALF_MS, 24'd0},
    // zero delays act as 1 ms, zero count as a single flash
    '{ROW_CFG,  REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_CFG,  REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_FLASH_COUNT,   24'd0},
    '{ROW_CFG,  REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_FLASH_ON_MS,   24'd0},
    '{ROW_CFG,  REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_FLASH_OFF_MS,  24'd1},
    '{ROW_CFG,  REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_PWM_PERIOD,    PWM_FULL},
    '{ROW_ITEM, REQ_SET,  ST_SEARCHING,    1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_TICK, ST_MQTT,         1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    // flash over searching, then back to the blink once it runs out
    '{ROW_ITEM, REQ_SET,  ST_PUB_OK,       1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    // stable request cancels a running flash at once
    '{ROW_ITEM, REQ_SET,  ST_PUB_ERR,      1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_LTE,          1'b1, WANT_LTE_FULL, CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_CFG,  REQ_TICK, ST_DISCONNECTED, 1'b0, NO_WANT,       CFG_PWM_PERIOD,    24'd0},
    '{ROW_ITEM, REQ_SET,  ST_ERROR,        1'b1, WANT_DARK_ERR, CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_PUB_OK,       1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0},
    '{ROW_ITEM, REQ_SET,  ST_INVALID,      1'b0, NO_WANT,       CFG_BLINK_HALF_MS, 24'd0}
  };

  // --------------------------------------------------------------------------
  // LED pattern model: own copy of the timings and sequencer state
  // --------------------------------------------------------------------------
  cfg_t       timing = '{16'd250, 4'd5, 16'd150, 16'd150, 24'd20000};
  status_t    stable_now   = ST_DISCONNECTED;
  status_t    shown_now    = ST_DISCONNECTED;
  logic       blink_lit    = 1'b0;
  logic       blink_run    = 1'b0;
  ms_t        blink_left   = '0;
  logic       flash_lit    = 1'b0;
  logic       flash_run    = 1'b0;
  ms_t        flash_left   = '0;
  logic [3:0] flash_phases = '0;

  result_t led_expect_q [$];     // predicted LED items, oldest first
  int      err_count = 0;
  int      tx_idle_pct = 0;      // sender gap chance per item, percent
  int      rx_idle_pct = 0;      // receiver stall chance per cycle, percent
  bit      rx_hold_req = 1'b0;   // asks the receiver for one long hold-off

  // One tick of a countdown; a value of 0 or 1 expires now
  function automatic logic tick_expired(inout ms_t left);
    if (left <= 16'd1) begin
      left = '0;
      return 1'b1;
    end
    left = left - 16'd1;
    return 1'b0;
  endfunction

  function automatic pulse_t scaled_pulse(input logic lit);
    longint unsigned level;
    level = lit ? LEVEL_FULL : 64'd0;
    return pulse_t'((64'(timing.pwm_period) * level) / LEVEL_FULL);
  endfunction

  // Advance the model by one accepted item and return the LED item it causes
  function automatic result_t predict_led_item(input logic req, input status_t code);
    result_t    r;
    logic       blink_was;
    logic       flash_was;
    logic       lit;
    logic [2:0] rgb;
    r         = '0;
    blink_was = blink_run;
    flash_was = flash_run;
    if (req == REQ_TICK) begin
      // both timers sample their armed state before either fires
      if (blink_was) begin
        if (tick_expired(blink_left)) begin
          if (shown_now == ST_SEARCHING) begin
            blink_lit  = !blink_lit;
            blink_run  = 1'b1;
            blink_left = timing.blink_half_ms;
          end else begin
            blink_lit = 1'b0;
            blink_run = 1'b0;
          end
        end
      end
      if (flash_was) begin
        if (tick_expired(flash_left)) begin
          if (flash_lit) begin
            flash_lit  = 1'b0;
            flash_left = timing.flash_off_ms;
          end else if (flash_phases > 4'd1) begin
            flash_phases = flash_phases - 4'd1;
            flash_lit    = 1'b1;
            flash_left   = timing.flash_on_ms;
          end else begin
            // flash done: fall back to the stable pattern
            flash_phases = '0;
            flash_lit    = 1'b0;
            flash_run    = 1'b0;
            shown_now    = stable_now;
            blink_lit    = (shown_now == ST_SEARCHING);
            if (blink_lit) begin
              blink_run  = 1'b1;
              blink_left = timing.blink_half_ms;
            end
          end
        end
      end
    end else if (code == ST_INVALID) begin
      r.bad_request = 1'b1;
    end else if (code == ST_PUB_OK || code == ST_PUB_ERR) begin
      shown_now    = code;
      blink_lit    = 1'b0;
      blink_run    = 1'b0;
      blink_left   = '0;
      flash_lit    = 1'b1;
      flash_run    = 1'b1;
      flash_phases = timing.flash_count;
      flash_left   = timing.flash_on_ms;
    end else begin
      stable_now = code;
      shown_now  = code;
      flash_run  = 1'b0;
      flash_lit  = 1'b0;
      flash_left = '0;
      blink_lit  = (code == ST_SEARCHING);
      blink_run  = (code == ST_SEARCHING);
      blink_left = (code == ST_SEARCHING) ? timing.blink_half_ms : '0;
    end

    if (flash_run) lit = flash_lit;
    else lit = !(shown_now == ST_SEARCHING && !blink_lit);
    case (shown_now)
      ST_DISCONNECTED, ST_ERROR, ST_PUB_ERR: rgb = RGB_RED;
      ST_SEARCHING:                          rgb = RGB_BLUE;
      ST_LTE:                                rgb = RGB_GREEN;
      ST_MQTT:                               rgb = RGB_CYAN;
      ST_PUB_OK:                             rgb = RGB_WHITE;
      default:                               rgb = RGB_OFF;
    endcase
    if (!lit) rgb = RGB_OFF;

    r.red_pulse   = scaled_pulse(rgb[2]);
    r.green_pulse = scaled_pulse(rgb[1]);
    r.blue_pulse  = scaled_pulse(rgb[0]);
    r.stable_code = stable_now;
    r.shown_code  = shown_now;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one item, optionally after a random gap; valid is left high so a
  // back-to-back item needs no second assignment in the same step.
  task automatic send_item(input logic req, input status_t code,
                           input logic typed, input result_t want);
    result_t predicted;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.status_code <= code;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_led_item(req, code);
    led_expect_q.push_back(typed ? want : predicted);
  endtask

  // Stop offering until every predicted item has come out, then let the
  // pipe settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // One register write; write enable stays high for a following write
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_BLINK_HALF_MS: timing.blink_half_ms = val[15:0];
      CFG_FLASH_COUNT:   timing.flash_count   = val[3:0];
      CFG_FLASH_ON_MS:   timing.flash_on_ms   = val[15:0];
      CFG_FLASH_OFF_MS:  timing.flash_off_ms  = val[15:0];
      CFG_PWM_PERIOD:    timing.pwm_period    = val[23:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random ready, one long hold-off on request, and the check
  // of every accepted LED item against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_led_item(input result_t got);
    result_t want;
    if (led_expect_q.size() == 0) begin
      $error("LED item with no prediction waiting");
      err_count++;
      return;
    end
    want = led_expect_q.pop_front();
    if (got.red_pulse !== want.red_pulse) begin
      $error("red_pulse: expected %0d, got %0d", want.red_pulse, got.red_pulse);
      err_count++;
    end
    if (got.green_pulse !== want.green_pulse) begin
      $error("green_pulse: expected %0d, got %0d", want.green_pulse, got.green_pulse);
      err_count++;
    end
    if (got.blue_pulse !== want.blue_pulse) begin
      $error("blue_pulse: expected %0d, got %0d", want.blue_pulse, got.blue_pulse);
      err_count++;
    end
    if (got.stable_code !== want.stable_code) begin
      $error("stable_code: expected %0d, got %0d", want.stable_code, got.stable_code);
      err_count++;
    end
    if (got.shown_code !== want.shown_code) begin
      $error("shown_code: expected %0d, got %0d", want.shown_code, got.shown_code);
      err_count++;
    end
    if (got.bad_request !== want.bad_request) begin
      $error("bad_request: expected %0d, got %0d", want.bad_request, got.bad_request);
      err_count++;
    end
  endtask

  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        check_led_item('{out_ch.red_pulse, out_ch.green_pulse, out_ch.blue_pulse,
                         out_ch.stable_code, out_ch.shown_code, out_ch.bad_request});
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: too long without any handshake on either channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t    next_timing;
    logic    req;
    status_t code;
    int      roll;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_BLINK_HALF_MS;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_TICK;
    in_ch.status_code = ST_DISCONNECTED;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, sender lightly and receiver heavily idle
    tx_idle_pct = 8;
    rx_idle_pct = 55;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_item(directed_rows[i].req, directed_rows[i].code,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: each one loads a full set of timings while idle.
    // Other phases keep timers short so flashes and blinks turn over within a phase;
    // one phase takes every register to its top value.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1: next_timing = '{16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF, PWM_FULL};
        4: next_timing = '{16'd1, 4'd1, 16'd0, 16'd0, pulse_t'($urandom)};
        default: begin
          next_timing.blink_half_ms = ms_t'($urandom_range(0, 9));
          next_timing.flash_count   = 4'($urandom_range(0, 15));
          next_timing.flash_on_ms   = ms_t'($urandom_range(0, 5));
          next_timing.flash_off_ms  = ms_t'($urandom_range(0, 5));
          next_timing.pwm_period    = ($urandom_range(0, 3) == 0) ? PWM_FULL
                                                                  : pulse_t'($urandom);
        end
      endcase

      // sender lightly / receiver heavily idle, then swapped, then none
      tx_idle_pct = (p < 2) ? 8 : (p < 4) ? 55 : 0;
      rx_idle_pct = (p < 2) ? 55 : (p < 4) ? 8 : 0;

      wait_drained();
      write_reg(CFG_BLINK_HALF_MS, CFG_DATA_W'(next_timing.blink_half_ms));
      write_reg(CFG_FLASH_COUNT,   CFG_DATA_W'(next_timing.flash_count));
      write_reg(CFG_FLASH_ON_MS,   CFG_DATA_W'(next_timing.flash_on_ms));
      write_reg(CFG_FLASH_OFF_MS,  CFG_DATA_W'(next_timing.flash_off_ms));
      write_reg(CFG_PWM_PERIOD,    next_timing.pwm_period);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off with the sender flat out: block backs up
        if (p == 4 && n == 40) rx_hold_req = 1'b1;
        // sender pause until all results are out, mid-phase
        if (p == 3 && n == 60) wait_drained();

        // mostly ticks so timers run; requests lean to searching and publish
        roll = $urandom_range(0, 99);
        req  = (roll < 70) ? REQ_TICK : REQ_SET;
        code = status_t'($urandom_range(0, 7));
        if (req == REQ_SET && roll >= 88) begin
          code = (roll >= 94) ? ST_SEARCHING
                              : status_t'($urandom_range(ST_PUB_OK, ST_PUB_ERR));
        end
        send_item(req, code, 1'b0, NO_WANT);
      end
    end

    in_ch.valid <= 1'b0;
    while (led_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
